@@ design/timestamp_date_plausibility_check_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the timestamp date plausibility check unit
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef TIMESTAMP_DATE_PLAUSIBILITY_CHECK_UNIT_DEFINES_SVH
`define TIMESTAMP_DATE_PLAUSIBILITY_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication
`define TDPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TDPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tdpc_pkg.sv @@
// ---------------------------------------------------------------------------
// tdpc_pkg
// Types, constants and constant-divisor helpers of the date plausibility check.
// ---------------------------------------------------------------------------
`default_nettype none

package tdpc_pkg;

    // Pipeline depth, input register through output register
    localparam int NUM_STG = 17;

    // Configuration register indexes
    localparam logic CFG_LO_OFS = 1'b0;
    localparam logic CFG_HI_OFS = 1'b1;

    // Window lanes
    localparam int LANE_LO = 0;
    localparam int LANE_HI = 1;

    // Seconds bias: shifts the epoch to 0000-03-01 and adds eight 400-year eras,
    // so every reachable second count is positive.
    localparam logic [38:0] DAY_BIAS_SEC  = 39'd163144281600;
    localparam logic [38:0] LO_OB_RST     = DAY_BIAS_SEC - 39'd43200;
    localparam logic [38:0] HI_OB_RST     = DAY_BIAS_SEC + 39'd50400;
    localparam logic [15:0] ERA_BIAS_YEARS = 16'd3200;

    // Exact reciprocals: shift = dividend bits + ceil(log2(divisor))
    localparam logic [19:0] RCP_125  = 20'(((64'd1 << 26) + 64'd124) / 64'd125);
    localparam logic [22:0] RCP_675  = 23'(((64'd1 << 32) + 64'd674) / 64'd675);
    localparam logic [22:0] RCP_ERA  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    localparam logic [18:0] RCP_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] RCP_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [11:0] RCP_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } t_claim;

    typedef logic [24:0] t_key;

    typedef struct packed {
        logic [11:0] q;
        logic [6:0]  r;
    } t_div125;

    typedef struct packed {
        logic [11:0] q;
        logic [9:0]  r;
    } t_div675;

    // One 12-bit digit of a long division by 125
    function automatic t_div125 f_div125(input logic [18:0] x);
        logic [38:0] prod;
        t_div125     res;
        prod  = 39'(x) * 39'(RCP_125);
        res.q = prod[37:26];
        res.r = 7'(x - 19'(res.q) * 19'd125);
        return res;
    endfunction

    // One 12-bit digit of a long division by 675
    function automatic t_div675 f_div675(input logic [21:0] x);
        logic [44:0] prod;
        t_div675     res;
        prod  = 45'(x) * 45'(RCP_675);
        res.q = prod[43:32];
        res.r = 10'(x - 22'(res.q) * 22'd675);
        return res;
    endfunction

    // Era of a biased day number
    function automatic logic [4:0] f_era(input logic [21:0] x);
        logic [44:0] prod;
        prod = 45'(x) * 45'(RCP_ERA);
        return prod[44:40];
    endfunction

    function automatic logic [6:0] f_div1460(input logic [17:0] x);
        logic [36:0] prod;
        prod = 37'(x) * 37'(RCP_1460);
        return prod[35:29];
    endfunction

    function automatic logic [8:0] f_div365(input logic [17:0] x);
        logic [36:0] prod;
        prod = 37'(x) * 37'(RCP_365);
        return prod[35:27];
    endfunction

    function automatic logic [3:0] f_div153(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'(RCP_153);
        return prod[22:19];
    endfunction

    // Days before the start of a March-based month
    function automatic logic [8:0] f_mp_days(input logic [3:0] mp);
        logic [8:0] days;
        unique case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

@@ design/timestamp_date_plausibility_check_unit.sv @@
// ---------------------------------------------------------------------------
// timestamp_date_plausibility_check_unit
// Checks a claimed calendar date against the UTC dates of a millisecond Unix
// time shifted by a lower and an upper offset.
//
//   channel  direction  handshake             payload
//   input    in         i_valid / o_ready     claimed year, month, day, millis
//   result   out        o_valid / i_ready     plausible flag
//   config   in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// One item per cycle through 17 register stages unless the result side stalls; o_valid
// is the valid bit of the last stage. The depth comes from the digit-by-digit divisions by
// 1000 and 86400 and the staged days-to-date conversion, one multiplier per stage.
// Reset clears all stage valid bits and loads the default offsets.
// Each full stage holds while its successor is full and not moving; empty stages
// keep filling, so input is taken while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none

`include "timestamp_date_plausibility_check_unit_defines.svh"

module timestamp_date_plausibility_check_unit
    import tdpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [17:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_claimed_year,
    input  logic [3:0]         i_claimed_month,
    input  logic [4:0]         i_claimed_day,
    input  logic signed [47:0] i_stamp_millis,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_plausible
);

    // Control
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] adv;

    // Biased offsets
    logic [38:0] r_ob [2];

    // Claim shift line
    t_claim r_clm [16];

    // Division by 1000: sign, dividend/quotient shifter, remainder
    logic        r_neg [5];
    logic [47:0] r_dq  [5];
    logic [6:0]  r_rm  [5];

    // Division by 86400, per lane
    logic [35:0] r_zq [2][4];
    logic [9:0]  r_zr [2][4];

    // Calendar stages, per lane
    logic [21:0] r_zb9   [2];
    logic [4:0]  r_era9  [2];
    logic [17:0] r_doe10 [2];
    logic [4:0]  r_era10 [2];
    logic [17:0] r_t11   [2];
    logic [17:0] r_doe11 [2];
    logic [4:0]  r_era11 [2];
    logic [8:0]  r_yoe12 [2];
    logic [17:0] r_doe12 [2];
    logic [4:0]  r_era12 [2];
    logic [8:0]  r_doy13 [2];
    logic [8:0]  r_yoe13 [2];
    logic [4:0]  r_era13 [2];
    logic [3:0]  r_mp14  [2];
    logic [8:0]  r_doy14 [2];
    logic [8:0]  r_yoe14 [2];
    logic [4:0]  r_era14 [2];
    t_key        r_key15 [2];
    logic        r_ok;

    // Next values
    logic [47:0] n_mag;
    t_div125     n_d125 [4];
    logic [38:0] n_secs;
    logic [38:0] n_sb   [2];
    t_div675     n_d675 [2][3];
    logic [17:0] n_t    [2];
    logic [8:0]  n_doy  [2];
    logic [3:0]  n_mon  [2];
    logic [4:0]  n_day  [2];
    logic [15:0] n_year [2];
    t_key        n_ckey;

    // Stage advance: a stage loads when it is empty or its successor moves
    always_comb begin
        adv[NUM_STG-1] = !r_vld[NUM_STG-1] || i_ready;
        for (int s = NUM_STG - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign n_vld   = {r_vld[NUM_STG-2:0], i_valid};
    assign o_ready = adv[0];
    assign o_valid = r_vld[NUM_STG-1];
    assign o_plausible = r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NUM_STG; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    // Offset registers, stored with the day bias folded in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob[LANE_LO] <= LO_OB_RST;
            r_ob[LANE_HI] <= HI_OB_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LO_OFS: r_ob[LANE_LO] <= DAY_BIAS_SEC + {{21{i_cfg_data[17]}}, i_cfg_data};
                CFG_HI_OFS: r_ob[LANE_HI] <= DAY_BIAS_SEC + {22'd0, i_cfg_data[16:0]};
                default:    r_ob[LANE_LO] <= r_ob[LANE_LO];
            endcase
        end
    end

    // Datapath next values
    always_comb begin
        // Magnitude of the millisecond count
        n_mag = i_stamp_millis[47] ? (48'd0 - 48'(i_stamp_millis)) : 48'(i_stamp_millis);

        // Divide by 125, one 12-bit digit a stage
        for (int k = 0; k < 4; k++) begin
            n_d125[k] = f_div125({r_rm[k], r_dq[k][47:36]});
        end

        // Apply the sign: whole seconds, truncated toward zero
        n_secs = r_neg[4] ? (39'd0 - r_dq[4][38:0]) : r_dq[4][38:0];

        for (int l = 0; l < 2; l++) begin
            n_sb[l] = r_ob[l] + n_secs;

            // Divide by 675, one 12-bit digit a stage
            for (int k = 0; k < 3; k++) begin
                n_d675[l][k] = f_div675({r_zr[l][k], r_zq[l][k][35:24]});
            end

            // Year-of-era numerator
            n_t[l] = r_doe10[l] - 18'(f_div1460(r_doe10[l]))
                   + 18'(r_doe10[l] >= 18'd36524) + 18'(r_doe10[l] >= 18'd73048)
                   + 18'(r_doe10[l] >= 18'd109572) + 18'(r_doe10[l] >= 18'd146096)
                   - 18'(r_doe10[l] == 18'd146096);

            // Day of the March-based year
            n_doy[l] = 9'(r_doe12[l] - (18'(r_yoe12[l]) * 18'd365
                     + 18'(r_yoe12[l][8:2])
                     - 18'(r_yoe12[l] >= 9'd100) - 18'(r_yoe12[l] >= 9'd200)
                     - 18'(r_yoe12[l] >= 9'd300)));

            // Civil month, day and year
            n_mon[l]  = (r_mp14[l] < 4'd10) ? (r_mp14[l] + 4'd3) : (r_mp14[l] - 4'd9);
            n_day[l]  = 5'(r_doy14[l] - f_mp_days(r_mp14[l]) + 9'd1);
            n_year[l] = 16'(r_yoe14[l]) + 16'(r_era14[l]) * 16'd400
                      + {15'd0, (n_mon[l] <= 4'd2)} - ERA_BIAS_YEARS;
        end

        // Order key of the claim: biased year, month, day
        n_ckey = {~r_clm[15].year[15], r_clm[15].year[14:0], r_clm[15].month,
                  r_clm[15].day};
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // Input stage
        if (adv[0]) begin
            r_clm[0] <= '{year: i_claimed_year, month: i_claimed_month,
                          day: i_claimed_day};
            r_neg[0] <= i_stamp_millis[47];
            r_dq[0]  <= {3'd0, n_mag[47:3]};
            r_rm[0]  <= '0;
        end

        // Claim travels alongside
        for (int s = 1; s < 16; s++) begin
            if (adv[s]) begin
                r_clm[s] <= r_clm[s-1];
            end
        end

        // Divide by 125: shift quotient digits in from the bottom
        for (int k = 0; k < 4; k++) begin
            if (adv[k+1]) begin
                r_neg[k+1] <= r_neg[k];
                r_dq[k+1]  <= {r_dq[k][35:0], n_d125[k].q};
                r_rm[k+1]  <= n_d125[k].r;
            end
        end

        for (int l = 0; l < 2; l++) begin
            // Add offset, divide by 128
            if (adv[5]) begin
                r_zq[l][0] <= {4'd0, n_sb[l][38:7]};
                r_zr[l][0] <= '0;
            end

            // Divide by 675
            for (int k = 0; k < 3; k++) begin
                if (adv[k+6]) begin
                    r_zq[l][k+1] <= {r_zq[l][k][23:0], n_d675[l][k].q};
                    r_zr[l][k+1] <= n_d675[l][k].r;
                end
            end

            // Era
            if (adv[9]) begin
                r_zb9[l]  <= r_zq[l][3][21:0];
                r_era9[l] <= f_era(r_zq[l][3][21:0]);
            end

            // Day of era
            if (adv[10]) begin
                r_doe10[l] <= 18'(r_zb9[l] - 22'(r_era9[l]) * 22'd146097);
                r_era10[l] <= r_era9[l];
            end

            if (adv[11]) begin
                r_t11[l]   <= n_t[l];
                r_doe11[l] <= r_doe10[l];
                r_era11[l] <= r_era10[l];
            end

            // Year of era
            if (adv[12]) begin
                r_yoe12[l] <= f_div365(r_t11[l]);
                r_doe12[l] <= r_doe11[l];
                r_era12[l] <= r_era11[l];
            end

            if (adv[13]) begin
                r_doy13[l] <= n_doy[l];
                r_yoe13[l] <= r_yoe12[l];
                r_era13[l] <= r_era12[l];
            end

            // March-based month
            if (adv[14]) begin
                r_mp14[l]  <= f_div153(11'(r_doy13[l]) * 11'd5 + 11'd2);
                r_doy14[l] <= r_doy13[l];
                r_yoe14[l] <= r_yoe13[l];
                r_era14[l] <= r_era13[l];
            end

            // Bound date as an order key
            if (adv[15]) begin
                r_key15[l] <= {~n_year[l][15], n_year[l][14:0], n_mon[l], n_day[l]};
            end
        end

        // Window compare into the output register
        if (adv[16]) begin
            r_ok <= (r_key15[LANE_LO] <= n_ckey) && (n_ckey <= r_key15[LANE_HI]);
        end
    end

    // Checks
    `TDPC_ASSERT_NXT(a_accept_enters, i_valid && o_ready, r_vld[0], "accepted item lost at entry")
    `TDPC_ASSERT_IMP(a_full_stall, (&r_vld) && !i_ready, !o_ready, "full pipe took an item")
    `TDPC_ASSERT_IMP(a_rem125, r_vld[4], r_rm[4] < 7'd125, "remainder by 125 out of range")
    `TDPC_ASSERT_IMP(a_rem675, r_vld[8], (r_zr[0][3] < 10'd675) && (r_zr[1][3] < 10'd675), "bad rem")
    `TDPC_ASSERT_IMP(a_mp_range, r_vld[14], (r_mp14[0] <= 4'd11) && (r_mp14[1] <= 4'd11), "bad mp")

endmodule

`default_nettype wire

@@ bench/tb_timestamp_date_plausibility_check_unit.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_timestamp_date_plausibility_check_unit
// Self-checking bench for the date plausibility check. A behavioral model
// converts each millisecond stamp, shifted by both offsets, to UTC dates and
// predicts the window flag. Results are compared in order as they come out.
// Stimulus: directed epoch, truncation, calendar and extreme cases, then
// random stamps with claims drawn around the offset window, under several
// offset settings, with random stalls on both channels.
// ---------------------------------------------------------------------------

module tb_timestamp_date_plausibility_check_unit;
    import tdpc_pkg::*;

    localparam longint SECS_PER_DAY = 86400;
    localparam longint ERA_DAYS     = 146097;
    localparam longint EPOCH_SHIFT  = 719468;
    localparam int     ITEMS_PER_PHASE = 212;

    typedef struct {
        longint y;
        longint m;
        longint d;
    } t_civil;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [17:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_claimed_year;
    logic [3:0]         i_claimed_month;
    logic [4:0]         i_claimed_day;
    logic signed [47:0] i_stamp_millis;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_plausible;

    // Offset copy used by the predictor
    longint lo_ofs_s;
    longint hi_ofs_s;

    // Pending window flags, oldest first
    bit     plausible_q[$];
    bit     flag_due;
    bit     calm;
    int     mismatches;
    int     items_sent;
    int     results_checked;
    int     in_window;
    int     windows_used;

    timestamp_date_plausibility_check_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_claimed_year  (i_claimed_year),
        .i_claimed_month (i_claimed_month),
        .i_claimed_day   (i_claimed_day),
        .i_stamp_millis  (i_stamp_millis),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_plausible     (o_plausible)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Date model
    // ---------------------------------------------------------------------

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q -= 1;
        return q;
    endfunction

    // Seconds since the epoch to a proleptic Gregorian UTC date
    function automatic t_civil secs_to_civil(input longint secs);
        longint z, era, doe, yoe, doy, mp;
        t_civil r;
        z   = floor_div(secs, SECS_PER_DAY) + EPOCH_SHIFT;
        era = floor_div(z, ERA_DAYS);
        doe = z - era * ERA_DAYS;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        r.d = doy - (153 * mp + 2) / 5 + 1;
        r.m = (mp < 10) ? mp + 3 : mp - 9;
        r.y = yoe + era * 400 + ((r.m <= 2) ? 1 : 0);
        return r;
    endfunction

    function automatic bit civil_not_after(input t_civil a, input t_civil b);
        if (a.y != b.y)
            return a.y < b.y;
        if (a.m != b.m)
            return a.m < b.m;
        return a.d <= b.d;
    endfunction

    function automatic bit predict_plausible(input t_claim c, input logic signed [47:0] ms);
        longint ms64, secs;
        t_civil lo, hi, cl;
        ms64 = ms;
        // Milliseconds to seconds truncates toward zero
        secs = ms64 / 1000;
        lo   = secs_to_civil(secs + lo_ofs_s);
        hi   = secs_to_civil(secs + hi_ofs_s);
        cl.y = longint'(signed'(c.year));
        cl.m = c.month;
        cl.d = c.day;
        return civil_not_after(lo, cl) && civil_not_after(cl, hi);
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic t_claim make_claim(input int y, input int m, input int d);
        t_claim c;
        c.year  = 16'(y);
        c.month = 4'(m);
        c.day   = 5'(d);
        return c;
    endfunction

    // Claim equal to the UTC date of the stamp shifted by delta seconds
    function automatic t_claim claim_at(input logic signed [47:0] ms, input longint delta);
        longint ms64;
        t_civil d;
        ms64 = ms;
        d = secs_to_civil(ms64 / 1000 + delta);
        return make_claim(int'(d.y), int'(d.m), int'(d.d));
    endfunction

    function automatic logic signed [47:0] pick_millis();
        longint k, v;
        case ($urandom_range(4))
            0: v = longint'({$urandom, $urandom});
            1: v = longint'($urandom_range(4000)) - 2000;
            2: begin
                // Near a midnight, anywhere in the stamp range
                k = longint'($urandom_range(3200000)) - 1600000;
                v = k * SECS_PER_DAY * 1000 + longint'($urandom_range(4000)) - 2000;
            end
            3: begin
                v = longint'($urandom) * 1000 + longint'($urandom_range(999));
                if ($urandom_range(1))
                    v = -v;
            end
            default: begin
                v = (longint'(1) << 47) - 1 - longint'($urandom_range(200000000));
                if ($urandom_range(1))
                    v = -v - 1;
            end
        endcase
        return 48'(v);
    endfunction

    // Mostly claims around the offset window, with some raw noise
    function automatic t_claim pick_claim(input logic signed [47:0] ms);
        longint span;
        t_claim c;
        span = hi_ofs_s - lo_ofs_s + 2 * 90000;
        if (span < 0)
            span = 2 * 90000;
        c = claim_at(ms, lo_ofs_s - 90000 + longint'($urandom_range(int'(span))));
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: c.year  = 16'($urandom);
                1: c.month = 4'($urandom);
                2: c.day   = 5'($urandom);
                default: c = t_claim'(25'($urandom));
            endcase
        end
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // Channel tasks
    // ---------------------------------------------------------------------

    // Offer one item, hold it until taken, then queue its flag
    task automatic send_item(input t_claim c, input logic signed [47:0] ms);
        bit flag;
        flag = predict_plausible(c, ms);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_claimed_year  <= c.year;
        i_claimed_month <= c.month;
        i_claimed_day   <= c.day;
        i_stamp_millis  <= ms;
        do @(posedge i_clk); while (!o_ready);
        plausible_q.push_back(flag);
        items_sent++;
    endtask

    // Drop valid and hold until every pending result is out
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (plausible_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both offsets; bit 17 of the upper word is junk and must be ignored
    task automatic set_window(input logic signed [17:0] lo, input logic [16:0] hi);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LO_OFS;
        i_cfg_data <= lo;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_HI_OFS;
        i_cfg_data <= {1'($urandom), hi};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        lo_ofs_s = lo;
        hi_ofs_s = hi;
        windows_used++;
    endtask

    // Randomly stall the result side
    always @(negedge i_clk)
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);

    // Compare each result with the oldest pending flag
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            if (o_plausible === 1'b1)
                in_window++;
            if (plausible_q.size() == 0) begin
                $error("plausible: expected no result, got %0b", o_plausible);
                mismatches++;
            end else begin
                flag_due = plausible_q.pop_front();
                if (o_plausible !== flag_due) begin
                    $error("plausible: expected %0b, got %0b", flag_due, o_plausible);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Directed cases under the reset offsets (-12 h, +14 h)
    task automatic test_reset_window();
        logic signed [47:0] ms_max, ms_min;
        ms_max = 48'sh7FFF_FFFF_FFFF;
        ms_min = 48'sh8000_0000_0000;
        // Epoch and both window edges
        send_item(make_claim(1970, 1, 1), 48'sd0);
        send_item(make_claim(1969, 12, 31), 48'sd0);
        send_item(make_claim(1970, 1, 2), 48'sd0);
        send_item(make_claim(1970, 1, 2), 48'sd36000000);
        send_item(make_claim(1970, 1, 2), 48'sd35999999);
        // Negative stamps: truncation to seconds, then floor to days
        send_item(make_claim(1970, 1, 1), -48'sd1);
        send_item(make_claim(1969, 12, 30), -48'sd43200999);
        send_item(make_claim(1969, 12, 30), -48'sd43201000);
        // Month and day outside the calendar, compared as plain numbers
        send_item(make_claim(1969, 15, 31), 48'sd0);
        send_item(make_claim(1970, 0, 0), 48'sd0);
        send_item(make_claim(1970, 13, 1), 48'sd0);
        send_item(make_claim(1970, 1, 31), 48'sd0);
        // Leap days and century rules
        send_item(make_claim(2000, 2, 29), 48'sd951782400000);
        send_item(make_claim(1900, 2, 29), -48'sd2203891200000);
        send_item(claim_at(-48'sd2203891200000, 0), -48'sd2203891200000);
        send_item(claim_at(48'sd4107542400000, -86400), 48'sd4107542400000);
        // Stamp and year extremes
        send_item(claim_at(ms_max, 0), ms_max);
        send_item(claim_at(ms_min, 0), ms_min);
        send_item(make_claim(32767, 15, 31), ms_max);
        send_item(make_claim(-32768, 0, 0), ms_min);
        send_item(claim_at(ms_min, -43200), ms_min);
        send_item(claim_at(ms_max, 50400), ms_max);
        drain_results();
    endtask

    // Extreme offset settings, including inverted and out-of-range windows
    task automatic test_offset_extremes();
        logic signed [17:0] lo_set[5];
        logic [16:0]        hi_set[5];
        logic signed [47:0] ms;
        lo_set = '{-18'sd86400, 18'sd0, -18'sd131072, 18'sd131071, -18'sd1};
        hi_set = '{17'd86400, 17'd0, 17'd131071, 17'd0, 17'd1};
        foreach (lo_set[i]) begin
            set_window(lo_set[i], hi_set[i]);
            repeat (16) begin
                ms = pick_millis();
                send_item(pick_claim(ms), ms);
            end
            drain_results();
        end
    endtask

    // Bulk random traffic over several offset settings
    task automatic test_random_traffic();
        logic signed [47:0] ms;
        for (int p = 0; p < 5; p++) begin
            case (p)
                2: set_window(18'($urandom), 17'($urandom));
                4: set_window(-18'sd86400, 17'd86400);
                default: set_window(-18'($urandom_range(86400)), 17'($urandom_range(86400)));
            endcase
            // One phase runs with no stalls on either side
            calm = (p == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                ms = pick_millis();
                send_item(pick_claim(ms), ms);
            end
            drain_results();
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LO_OFS;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_claimed_year  = '0;
        i_claimed_month = '0;
        i_claimed_day   = '0;
        i_stamp_millis  = '0;
        calm            = 1'b0;
        lo_ofs_s        = -43200;
        hi_ofs_s        = 50400;
        mismatches      = 0;
        items_sent      = 0;
        results_checked = 0;
        in_window       = 0;
        windows_used    = 1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_offset_extremes();
        test_random_traffic();

        drain_results();
        repeat (2 * NUM_STG) @(posedge i_clk);

        $display("Checked %0d results for %0d items across %0d offset settings.",
                 results_checked, items_sent, windows_used);
        $display("%0d of them fell inside the date window.", in_window);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop if the pipeline hangs
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
